// ===== rtl/rctr_pkg.sv =====
// Shared types, widths and register codes of the RC time-ratio resistance meter.
package rctr_pkg;

  localparam int TICK_W    = 32;
  localparam int RAT_W     = 32;
  localparam int REF_W     = 20;
  localparam int THR_W     = 32;
  localparam int CNT_W     = 8;
  localparam int SEL_W     = 3;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WARMUP_EVENTS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCAN_PERIOD       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REF_HIGH_OHMS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REF_LOW_OHMS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TO_LOW_REF_BELOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TO_HIGH_REF_ABOVE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CAP_ADD_BELOW     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CAP_REMOVE_ABOVE  = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] warmup_events;
    logic [CNT_W-1:0] scan_period;
    logic [REF_W-1:0] ref_high_ohms;
    logic [REF_W-1:0] ref_low_ohms;
    logic [THR_W-1:0] to_low_ref_below;
    logic [THR_W-1:0] to_high_ref_above;
    logic [THR_W-1:0] cap_add_below;
    logic [THR_W-1:0] cap_remove_above;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_OLD,
    ST_RANGE,
    ST_DIV,
    ST_DIV_END,
    ST_MUL_NEW,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic range;
    logic div_start;
    logic div_step;
    logic div_end;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sense;
    logic range_phase;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/rctr_regs.sv =====
// APB configuration register bank of the RC time-ratio resistance meter.
module rctr_regs import rctr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WARMUP_EVENTS:     cfg_nxt.warmup_events     = pwdata[CNT_W-1:0];
        REG_SCAN_PERIOD:       cfg_nxt.scan_period       = pwdata[CNT_W-1:0];
        REG_REF_HIGH_OHMS:     cfg_nxt.ref_high_ohms     = pwdata[REF_W-1:0];
        REG_REF_LOW_OHMS:      cfg_nxt.ref_low_ohms      = pwdata[REF_W-1:0];
        REG_TO_LOW_REF_BELOW:  cfg_nxt.to_low_ref_below  = pwdata[THR_W-1:0];
        REG_TO_HIGH_REF_ABOVE: cfg_nxt.to_high_ref_above = pwdata[THR_W-1:0];
        REG_CAP_ADD_BELOW:     cfg_nxt.cap_add_below     = pwdata[THR_W-1:0];
        REG_CAP_REMOVE_ABOVE:  cfg_nxt.cap_remove_above  = pwdata[THR_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WARMUP_EVENTS:     prdata = APB_DW'(cfg_r.warmup_events);
      REG_SCAN_PERIOD:       prdata = APB_DW'(cfg_r.scan_period);
      REG_REF_HIGH_OHMS:     prdata = APB_DW'(cfg_r.ref_high_ohms);
      REG_REF_LOW_OHMS:      prdata = APB_DW'(cfg_r.ref_low_ohms);
      REG_TO_LOW_REF_BELOW:  prdata = APB_DW'(cfg_r.to_low_ref_below);
      REG_TO_HIGH_REF_ABOVE: prdata = APB_DW'(cfg_r.to_high_ref_above);
      REG_CAP_ADD_BELOW:     prdata = APB_DW'(cfg_r.cap_add_below);
      REG_CAP_REMOVE_ABOVE:  prdata = APB_DW'(cfg_r.cap_remove_above);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_events     <= CNT_W'(5);
      cfg_r.scan_period       <= CNT_W'(10);
      cfg_r.ref_high_ohms     <= REF_W'(9862);
      cfg_r.ref_low_ohms      <= REF_W'(989);
      cfg_r.to_low_ref_below  <= THR_W'(2500);
      cfg_r.to_high_ref_above <= THR_W'(8000);
      cfg_r.cap_add_below     <= THR_W'(80000);
      cfg_r.cap_remove_above  <= THR_W'(100000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/rctr_ctrl.sv =====
// Sequencing state machine of the RC time-ratio resistance meter.
module rctr_ctrl import rctr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: begin
        cmd.mul   = 1'b1;
        state_nxt = st.sense ? ST_RANGE : ST_DONE;
      end
      ST_RANGE: begin
        cmd.range     = 1'b1;
        cmd.div_start = st.range_phase;
        state_nxt     = st.range_phase ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd.div_end = 1'b1;
        state_nxt   = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rctr_dpath.sv =====
// Datapath of the RC time-ratio resistance meter: state, multiplier, divider, result register.
module rctr_dpath import rctr_pkg::*; #(
  parameter int MUX_ROWS        = 8,
  parameter int MUX_COLS        = 8,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic              in_is_sense_edge,
  input  logic [TICK_W-1:0] in_elapsed_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_next_path,
  output logic              out_low_ref_on,
  output logic              out_second_cap_on,
  output logic [SEL_W-1:0]  out_row_select,
  output logic [SEL_W-1:0]  out_col_select,
  output logic              out_estimate_valid,
  output logic [RAT_W-1:0]  out_estimate_ohms,
  output logic              out_scan_wrapped
);

  localparam int F    = RATIO_FRAC_BITS;
  localparam int RIW  = (MUX_ROWS > 1) ? $clog2(MUX_ROWS) : 1;
  localparam int CIW  = (MUX_COLS > 1) ? $clog2(MUX_COLS) : 1;
  localparam int DW   = TICK_W + F;
  localparam int DCW  = $clog2(DW);
  localparam int PW   = RAT_W + REF_W;
  localparam int TW   = THR_W + F;
  localparam int CMPW = (TW > PW) ? TW : PW;

  // Architectural state.
  logic              phase_r, phase_nxt;
  logic [TICK_W-1:0] times_r [2];
  logic [TICK_W-1:0] times_nxt [2];
  logic [RAT_W-1:0]  ratio_r, ratio_nxt;
  logic              low_ref_r, low_ref_nxt;
  logic              cap_r, cap_nxt;
  logic [CNT_W-1:0]  warm_r, warm_nxt;
  logic [CNT_W-1:0]  meas_r, meas_nxt;
  logic [RIW-1:0]    row_r, row_nxt;
  logic [CIW-1:0]    col_r, col_nxt;

  // Working registers of one request.
  logic              sense_r, sense_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [DCW-1:0]    cnt_r, cnt_nxt;
  logic              est_valid_r, est_valid_nxt;
  logic [RAT_W-1:0]  est_r, est_nxt;
  logic              wrap_r, wrap_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic              o_path_r, o_low_r, o_cap_r, o_ev_r, o_wrap_r;
  logic [SEL_W-1:0]  o_row_r, o_col_r;
  logic [RAT_W-1:0]  o_est_r;

  logic [REF_W-1:0]  ref_act;
  logic [CMPW-1:0]   prod_c, thr_lo, thr_hi, thr_ca, thr_cr;
  logic              rg_low, rg_cap, rg_phase, rg_warm;
  logic [TICK_W:0]   r_sh, dvs, r_diff;
  logic              q_ge;
  logic              ratio_sat;
  logic [PW-1:0]     est_full;
  logic              est_sat;

  assign ref_act = low_ref_r ? cfg.ref_low_ohms : cfg.ref_high_ohms;

  // Thresholds are compared against the exact product, scaled by 2^F.
  assign prod_c = CMPW'(prod_r);
  assign thr_lo = CMPW'({cfg.to_low_ref_below,  {F{1'b0}}});
  assign thr_hi = CMPW'({cfg.to_high_ref_above, {F{1'b0}}});
  assign thr_ca = CMPW'({cfg.cap_add_below,     {F{1'b0}}});
  assign thr_cr = CMPW'({cfg.cap_remove_above,  {F{1'b0}}});

  // Auto-ranging; the high-reference check sees the low-reference check's result.
  always_comb begin
    rg_low   = low_ref_r;
    rg_cap   = cap_r;
    rg_phase = phase_r;
    rg_warm  = warm_r < cfg.warmup_events;
    if (!rg_warm) begin
      if ((prod_c < thr_lo) && !rg_low) begin
        rg_low   = 1'b1;
        rg_phase = 1'b1;
      end
      if ((prod_c > thr_hi) && rg_low) begin
        rg_low   = 1'b0;
        rg_phase = 1'b1;
      end
      if ((prod_c < thr_ca) && !rg_cap) begin
        rg_cap   = 1'b1;
        rg_phase = 1'b1;
      end else if ((prod_c > thr_cr) && rg_cap) begin
        rg_cap   = 1'b0;
        rg_phase = 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign r_sh   = {rem_r, quo_r[DW-1]};
  assign dvs    = {1'b0, times_r[1]};
  assign q_ge   = r_sh >= dvs;
  assign r_diff = r_sh - dvs;

  assign ratio_sat = (times_r[1] == '0) || (quo_r[DW-1:RAT_W] != '0);

  assign est_full = prod_r >> F;
  assign est_sat  = (est_full >> RAT_W) != '0;

  always_comb begin
    phase_nxt     = phase_r;
    times_nxt     = times_r;
    ratio_nxt     = ratio_r;
    low_ref_nxt   = low_ref_r;
    cap_nxt       = cap_r;
    warm_nxt      = warm_r;
    meas_nxt      = meas_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sense_nxt     = sense_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    est_valid_nxt = est_valid_r;
    est_nxt       = est_r;
    wrap_nxt      = wrap_r;

    if (cmd.load_in) begin
      sense_nxt     = in_is_sense_edge;
      est_valid_nxt = 1'b0;
      est_nxt       = '0;
      wrap_nxt      = 1'b0;
      if (in_is_sense_edge) begin
        times_nxt[phase_r] = in_elapsed_ticks;
      end
    end

    if (cmd.mul) begin
      prod_nxt = {{REF_W{1'b0}}, ratio_r} * {{RAT_W{1'b0}}, ref_act};
    end

    if (cmd.range) begin
      low_ref_nxt = rg_low;
      cap_nxt     = rg_cap;
      phase_nxt   = rg_phase;
      if (rg_warm) begin
        warm_nxt = warm_r + CNT_W'(1);
      end
    end

    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = DW'({times_r[0], {F{1'b0}}});
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = q_ge ? r_diff[TICK_W-1:0] : r_sh[TICK_W-1:0];
      quo_nxt = {quo_r[DW-2:0], q_ge};
      cnt_nxt = cnt_r + DCW'(1);
    end

    if (cmd.div_end) begin
      ratio_nxt     = ratio_sat ? '1 : quo_r[RAT_W-1:0];
      meas_nxt      = (meas_r < cfg.scan_period) ? meas_r + CNT_W'(1) : '0;
      est_valid_nxt = 1'b1;
    end

    if (cmd.finish) begin
      if (est_valid_r) begin
        est_nxt = est_sat ? '1 : est_full[RAT_W-1:0];
      end
      phase_nxt = ~phase_r;
      // The scan steps on a return to the sensing resistor when meas_r equals scan_period.
      if (phase_r && (meas_r == cfg.scan_period)) begin
        if (col_r == CIW'(MUX_COLS - 1)) begin
          col_nxt = '0;
          if (row_r == RIW'(MUX_ROWS - 1)) begin
            row_nxt  = '0;
            wrap_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RIW'(1);
          end
        end else begin
          col_nxt = col_r + CIW'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      times_r[0]  <= '0;
      times_r[1]  <= '0;
      ratio_r     <= '0;
      low_ref_r   <= 1'b0;
      cap_r       <= 1'b0;
      warm_r      <= '0;
      meas_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      times_r     <= times_nxt;
      ratio_r     <= ratio_nxt;
      low_ref_r   <= low_ref_nxt;
      cap_r       <= cap_nxt;
      warm_r      <= warm_nxt;
      meas_r      <= meas_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sense_r     <= sense_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    est_valid_r <= est_valid_nxt;
    est_r       <= est_nxt;
    wrap_r      <= wrap_nxt;
    if (cmd.out_load) begin
      o_path_r <= phase_r;
      o_low_r  <= low_ref_r;
      o_cap_r  <= cap_r;
      o_row_r  <= SEL_W'(row_r);
      o_col_r  <= SEL_W'(col_r);
      o_ev_r   <= est_valid_r;
      o_est_r  <= est_r;
      o_wrap_r <= wrap_r;
    end
  end

  assign st.sense       = sense_r;
  assign st.range_phase = rg_phase;
  assign st.div_last    = cnt_r == DCW'(DW - 1);
  assign st.out_free    = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_next_path      = o_path_r;
  assign out_low_ref_on     = o_low_r;
  assign out_second_cap_on  = o_cap_r;
  assign out_row_select     = o_row_r;
  assign out_col_select     = o_col_r;
  assign out_estimate_valid = o_ev_r;
  assign out_estimate_ohms  = o_est_r;
  assign out_scan_wrapped   = o_wrap_r;

endmodule

// ===== rtl/rc_time_ratio_resistance_autorange.sv =====
// Top level of the RC time-ratio resistance meter with hysteretic auto-ranging.
//
// Each request carries one comparator threshold event and its RC charge time in
// timer ticks. A sense-edge request stores the time for the path being charged
// (sensing resistor or reference), runs the hysteretic auto-ranging once the
// warm-up count has passed, and on a reference request forms the charge-time
// ratio in unsigned fixed point with RATIO_FRAC_BITS fraction bits, saturated to
// 32 bits, along with a new resistance estimate. Requests that are not sense
// edges leave the state alone and return the current settings with no estimate.
// The block works on one request at a time; a finished result sits in an output
// register, so the next request is taken while the result waits for out_ready.
// A reference request runs the restoring divider, which produces one quotient
// bit per cycle. A sensing-resistor request skips the divider, unless a range
// switch forces it onto the reference path, in which case it takes the same
// steps as a reference request. The 32 x 20 bit product of ratio and reference
// resistance is computed in one registered step. Configuration registers sit on
// an APB port, register i at byte address 4*i, and should be written only while
// the block is idle.
module rc_time_ratio_resistance_autorange import rctr_pkg::*; #(
  parameter int MUX_ROWS        = 8,
  parameter int MUX_COLS        = 8,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input request channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_is_sense_edge,
  input  logic [TICK_W-1:0] in_elapsed_ticks,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_next_path,
  output logic              out_low_ref_on,
  output logic              out_second_cap_on,
  output logic [SEL_W-1:0]  out_row_select,
  output logic [SEL_W-1:0]  out_col_select,
  output logic              out_estimate_valid,
  output logic [RAT_W-1:0]  out_estimate_ohms,
  output logic              out_scan_wrapped,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t st;

  // Register bank; all ranging thresholds and reference values live here.
  rctr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller steps one request through multiply, ranging, divide and scan.
  rctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the meter state, the multiplier, the divider and the
  // output register.
  rctr_dpath #(
    .MUX_ROWS        (MUX_ROWS),
    .MUX_COLS        (MUX_COLS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .st                 (st),
    .in_is_sense_edge   (in_is_sense_edge),
    .in_elapsed_ticks   (in_elapsed_ticks),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_path      (out_next_path),
    .out_low_ref_on     (out_low_ref_on),
    .out_second_cap_on  (out_second_cap_on),
    .out_row_select     (out_row_select),
    .out_col_select     (out_col_select),
    .out_estimate_valid (out_estimate_valid),
    .out_estimate_ohms  (out_estimate_ohms),
    .out_scan_wrapped   (out_scan_wrapped)
  );

  // A result without a new estimate reports zero ohms.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_estimate_valid) |-> (out_estimate_ohms == '0))
    else $error("estimate reported without a valid estimate");

  // An estimate comes only from a request that ran the divider, after which the sensing
  // resistor is charged next.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_estimate_valid) |-> !out_next_path)
    else $error("estimate result does not return to the sensing path");

  // A scan wrap leaves both mux indexes at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scan_wrapped) |-> (out_row_select == '0 && out_col_select == '0))
    else $error("scan wrap with nonzero mux index");

  // The block never takes a new request while a finished result is being loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !(out_valid && $rose(out_valid) && $past(in_ready)))
    else $error("result loaded in the cycle after a request was accepted");

endmodule
